[design/ddo_pkg.sv]
// Shared types, constants and the arctangent table of the odometry block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package ddo_pkg;

    typedef struct packed {
        logic signed [31:0] velocity_a;
        logic signed [31:0] velocity_b;
        logic        [31:0] elapsed_time;
    } ddo_in_t;

    typedef struct packed {
        logic signed [47:0] pose_x;
        logic signed [47:0] pose_y;
        logic signed [31:0] pose_heading;
    } ddo_out_t;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_WHEEL_RADIUS      = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RADIUS_OVER_TRACK = 2'd1;

    localparam int MUL_A_W = 48;
    localparam int MUL_B_W = 32;
    localparam int DIGIT_W = 16;
    localparam int PP_W    = MUL_A_W + DIGIT_W;
    localparam int ACC_W   = MUL_A_W + MUL_B_W;

    localparam int ANG_W       = 34;
    localparam int ATAN_IDX_W  = 5;

    localparam logic [MUL_A_W-1:0]      TURN_SCALE  = 48'd44798133900177;
    localparam logic [MUL_A_W-1:0]      HALF_PI_Q30 = 48'd1686629713;
    localparam logic signed [ANG_W-1:0] CORDIC_GAIN = 34'sd652032874;

    localparam int OP_W = 3;
    localparam logic [OP_W-1:0] OP_PHASE = 3'd0;
    localparam logic [OP_W-1:0] OP_ANGLE = 3'd1;
    localparam logic [OP_W-1:0] OP_SPEED = 3'd2;
    localparam logic [OP_W-1:0] OP_RATE  = 3'd3;
    localparam logic [OP_W-1:0] OP_DIST  = 3'd4;
    localparam logic [OP_W-1:0] OP_DTH   = 3'd5;
    localparam logic [OP_W-1:0] OP_DX    = 3'd6;
    localparam logic [OP_W-1:0] OP_DY    = 3'd7;

    typedef struct packed {
        logic            load;
        logic            mul_start;
        logic [OP_W-1:0] mul_op;
        logic            wb;
        logic [OP_W-1:0] wb_op;
        logic            update;
    } ddo_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic cordic_busy;
    } ddo_status_t;

    function automatic logic [30:0] atan_q30(input logic [ATAN_IDX_W-1:0] idx);
        logic [30:0] v;
        unique case (idx)
            5'd0:  v = 31'd843314857;
            5'd1:  v = 31'd497837829;
            5'd2:  v = 31'd263043837;
            5'd3:  v = 31'd133525159;
            5'd4:  v = 31'd67021687;
            5'd5:  v = 31'd33543516;
            5'd6:  v = 31'd16775851;
            5'd7:  v = 31'd8388437;
            5'd8:  v = 31'd4194283;
            5'd9:  v = 31'd2097149;
            5'd10: v = 31'd1048576;
            5'd11: v = 31'd524288;
            5'd12: v = 31'd262144;
            5'd13: v = 31'd131072;
            5'd14: v = 31'd65536;
            5'd15: v = 31'd32768;
            5'd16: v = 31'd16384;
            5'd17: v = 31'd8192;
            5'd18: v = 31'd4096;
            5'd19: v = 31'd2048;
            5'd20: v = 31'd1024;
            5'd21: v = 31'd512;
            5'd22: v = 31'd256;
            5'd23: v = 31'd128;
            5'd24: v = 31'd64;
            5'd25: v = 31'd32;
            5'd26: v = 31'd16;
            5'd27: v = 31'd8;
            5'd28: v = 31'd4;
            5'd29: v = 31'd2;
            5'd30: v = 31'd1;
            default: v = 31'd0;
        endcase
        return v;
    endfunction

endpackage

`default_nettype wire

[design/ddo_mul.sv]
// Shared multi-cycle multiplier: 48-bit by 32-bit product built from two
// 48x16 partial products, formed in LO and HI and summed in ACC. Uses ddo_pkg.
`default_nettype none

module ddo_mul import ddo_pkg::*; (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic [MUL_A_W-1:0] a,
    input  wire logic [MUL_B_W-1:0] b,
    output logic                    done,
    output logic [ACC_W-1:0]        acc
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_LO   = 2'd1;
    localparam logic [1:0] ST_HI   = 2'd2;
    localparam logic [1:0] ST_ACC  = 2'd3;

    logic [1:0]         stage_reg, stage_next;
    logic               done_reg;
    logic [MUL_A_W-1:0] a_reg;
    logic [MUL_B_W-1:0] b_reg;
    logic [PP_W-1:0]    pp_reg, pp_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [DIGIT_W-1:0] digit;

    assign digit   = (stage_reg == ST_HI) ? b_reg[MUL_B_W-1:DIGIT_W] : b_reg[DIGIT_W-1:0];
    assign pp_next = PP_W'(a_reg) * PP_W'(digit);

    always_comb begin
        unique case (stage_reg)
            ST_IDLE: stage_next = start ? ST_LO : ST_IDLE;
            ST_LO:   stage_next = ST_HI;
            ST_HI:   stage_next = ST_ACC;
            ST_ACC:  stage_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            stage_reg <= stage_next;
            done_reg  <= (stage_reg == ST_ACC);
        end
    end

    always_ff @(posedge aclk) begin
        if (start && stage_reg == ST_IDLE) begin
            a_reg <= a;
            b_reg <= b;
        end
        if (stage_reg == ST_LO || stage_reg == ST_HI) begin
            pp_reg <= pp_next;
        end
        if (stage_reg == ST_HI) begin
            acc_reg <= ACC_W'(pp_reg);
        end else if (stage_reg == ST_ACC) begin
            acc_reg <= acc_reg + (ACC_W'(pp_reg) << DIGIT_W);
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;

endmodule

`default_nettype wire

[design/ddo_cordic.sv]
// Rotation-mode CORDIC giving cosine and sine of a first-quadrant angle,
// one iteration per cycle. Uses ddo_pkg for widths and the arctangent table.
`default_nettype none

module ddo_cordic import ddo_pkg::*; #(
    parameter int STEPS = 16
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic [30:0]             z_in,
    output logic                         busy,
    output logic signed [ANG_W-1:0]      x_out,
    output logic signed [ANG_W-1:0]      y_out
);

    localparam int ITER_W = $clog2(STEPS);

    logic                     busy_reg;
    logic [ITER_W-1:0]        iter_reg;
    logic signed [ANG_W-1:0]  x_reg, y_reg, z_reg;
    logic signed [ANG_W-1:0]  xs, ys, atan_step;

    assign xs        = x_reg >>> iter_reg;
    assign ys        = y_reg >>> iter_reg;
    assign atan_step = ANG_W'(atan_q30(ATAN_IDX_W'(iter_reg)));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            iter_reg <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            iter_reg <= '0;
        end else if (busy_reg) begin
            iter_reg <= iter_reg + ITER_W'(1);
            if (iter_reg == ITER_W'(STEPS - 1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            z_reg <= ANG_W'(z_in);
        end else if (busy_reg) begin
            if (!z_reg[ANG_W-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - atan_step;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + atan_step;
            end
        end
    end

    assign busy  = busy_reg;
    assign x_out = x_reg;
    assign y_out = y_reg;

endmodule

`default_nettype wire

[design/ddo_datapath.sv]
// Odometry datapath: configuration registers, input latch, operand select,
// rounding or truncating writeback and pose update; uses ddo_pkg, ddo_mul, ddo_cordic.
`default_nettype none

module ddo_datapath import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire ddo_in_t                in_data,
    input  wire ddo_cmd_t               cmd,
    output ddo_status_t                 status,
    output ddo_out_t                    out_data
);

    localparam int SPEED_W = 40;
    localparam int DIST_W  = 48;
    localparam int DELTA_W = 49;
    localparam int POS_W   = 48;
    localparam int HEAD_W  = 32;
    localparam int SUM_W   = POS_W + 3;
    localparam int SHIFT_W = 5;

    localparam logic [1:0] QUAD_I   = 2'd0;
    localparam logic [1:0] QUAD_II  = 2'd1;
    localparam logic [1:0] QUAD_III = 2'd2;
    localparam logic [1:0] QUAD_IV  = 2'd3;

    function automatic logic [POS_W-1:0] sat_pos(input logic [SUM_W-1:0] v);
        logic [POS_W-1:0] r;
        if (v[SUM_W-1] && !(&v[SUM_W-2:POS_W-1])) begin
            r = {1'b1, {(POS_W-1){1'b0}}};
        end else if (!v[SUM_W-1] && (|v[SUM_W-2:POS_W-1])) begin
            r = {1'b0, {(POS_W-1){1'b1}}};
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

    logic [CFG_DATA_W-1:0] wheel_radius_reg, radius_over_track_reg;
    logic [POS_W-1:0]      pos_x_reg, pos_y_reg;
    logic [HEAD_W-1:0]     heading_reg;

    logic [32:0]           sum_mag_reg;
    logic [31:0]           diff_mag_reg;
    logic                  sum_neg_reg, diff_neg_reg;
    logic [31:0]           dt_reg;
    logic [31:0]           phase_reg;
    logic [SPEED_W-1:0]    speed_reg, rate_reg;
    logic [DIST_W-1:0]     dist_reg;
    logic [HEAD_W-1:0]     dth_reg;
    logic [DELTA_W-1:0]    dx_reg, dy_reg;

    logic [32:0]           sum_raw, diff_raw, sum_mag, diff_abs;
    logic [MUL_A_W-1:0]    mul_a;
    logic [MUL_B_W-1:0]    mul_b;
    logic                  mul_done;
    logic [ACC_W-1:0]      acc;
    logic                  cordic_busy, cordic_start;
    logic signed [ANG_W-1:0] cx, cy, cos_v, sin_v;
    logic [ANG_W-1:0]      cos_abs, sin_abs;
    logic [MUL_B_W-1:0]    cos_mag, sin_mag;
    logic                  cos_neg, sin_neg;

    logic [SHIFT_W-1:0]    wb_shift;
    logic                  wb_round;
    logic [ACC_W-1:0]      rnd_val, wb_value;
    logic [31:0]           phase_value;

    logic [SUM_W-1:0]      x_step, y_step, x_sum, y_sum;
    logic [POS_W-1:0]      pos_x_next, pos_y_next;
    logic [HEAD_W-1:0]     heading_next;

    assign sum_raw  = {in_data.velocity_a[31], in_data.velocity_a}
                    + {in_data.velocity_b[31], in_data.velocity_b};
    assign diff_raw = {in_data.velocity_a[31], in_data.velocity_a}
                    - {in_data.velocity_b[31], in_data.velocity_b};
    assign sum_mag  = sum_raw[32] ? (~sum_raw + 33'd1) : sum_raw;
    assign diff_abs = diff_raw[32] ? (~diff_raw + 33'd1) : diff_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wheel_radius_reg      <= '0;
            radius_over_track_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_WHEEL_RADIUS:      wheel_radius_reg      <= cfg_wr_data;
                REG_RADIUS_OVER_TRACK: radius_over_track_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            sum_mag_reg  <= sum_mag;
            diff_mag_reg <= diff_abs[31:0];
            sum_neg_reg  <= sum_raw[32];
            diff_neg_reg <= diff_raw[32];
            dt_reg       <= in_data.elapsed_time;
        end
    end

    always_comb begin
        unique case (phase_reg[31:30])
            QUAD_I:   begin cos_v = cx;  sin_v = cy;  end
            QUAD_II:  begin cos_v = -cy; sin_v = cx;  end
            QUAD_III: begin cos_v = -cx; sin_v = -cy; end
            QUAD_IV:  begin cos_v = cy;  sin_v = -cx; end
        endcase
    end

    assign cos_neg = cos_v[ANG_W-1];
    assign sin_neg = sin_v[ANG_W-1];
    assign cos_abs = cos_neg ? -cos_v : cos_v;
    assign sin_abs = sin_neg ? -sin_v : sin_v;
    assign cos_mag = cos_abs[MUL_B_W-1:0];
    assign sin_mag = sin_abs[MUL_B_W-1:0];

    always_comb begin
        unique case (cmd.mul_op)
            OP_PHASE: begin mul_a = TURN_SCALE;             mul_b = heading_reg;           end
            OP_ANGLE: begin mul_a = HALF_PI_Q30;            mul_b = {2'b00, phase_reg[29:0]}; end
            OP_SPEED: begin mul_a = MUL_A_W'(sum_mag_reg);  mul_b = wheel_radius_reg;      end
            OP_RATE:  begin mul_a = MUL_A_W'(diff_mag_reg); mul_b = radius_over_track_reg; end
            OP_DIST:  begin mul_a = MUL_A_W'(speed_reg);    mul_b = dt_reg;                end
            OP_DTH:   begin mul_a = MUL_A_W'(rate_reg);     mul_b = dt_reg;                end
            OP_DX:    begin mul_a = dist_reg;               mul_b = cos_mag;               end
            OP_DY:    begin mul_a = dist_reg;               mul_b = sin_mag;               end
        endcase
    end

    ddo_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .done    (mul_done),
        .acc     (acc)
    );

    always_comb begin
        unique case (cmd.wb_op)
            OP_SPEED:                 begin wb_shift = 5'd25; wb_round = 1'b1; end
            OP_RATE, OP_DIST, OP_DTH: begin wb_shift = 5'd24; wb_round = 1'b1; end
            OP_DX, OP_DY:             begin wb_shift = 5'd30; wb_round = 1'b1; end
            OP_PHASE, OP_ANGLE:       begin wb_shift = 5'd30; wb_round = 1'b0; end
        endcase
    end

    assign rnd_val     = wb_round ? (ACC_W'(1) << (wb_shift - SHIFT_W'(1))) : '0;
    assign wb_value    = (acc + rnd_val) >> wb_shift;
    assign phase_value = acc[63:32] - (heading_reg[HEAD_W-1] ? TURN_SCALE[31:0] : 32'd0);

    assign cordic_start = cmd.wb && (cmd.wb_op == OP_ANGLE);

    ddo_cordic #(
        .STEPS (CORDIC_STEPS)
    ) u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cordic_start),
        .z_in    (wb_value[30:0]),
        .busy    (cordic_busy),
        .x_out   (cx),
        .y_out   (cy)
    );

    always_ff @(posedge aclk) begin
        if (cmd.wb) begin
            unique case (cmd.wb_op)
                OP_PHASE: phase_reg <= phase_value;
                OP_ANGLE: ;
                OP_SPEED: speed_reg <= wb_value[SPEED_W-1:0];
                OP_RATE:  rate_reg  <= wb_value[SPEED_W-1:0];
                OP_DIST:  dist_reg  <= wb_value[DIST_W-1:0];
                OP_DTH:   dth_reg   <= wb_value[HEAD_W-1:0];
                OP_DX:    dx_reg    <= wb_value[DELTA_W-1:0];
                OP_DY:    dy_reg    <= wb_value[DELTA_W-1:0];
            endcase
        end
    end

    assign x_step = (sum_neg_reg ^ cos_neg) ? (~SUM_W'(dx_reg) + SUM_W'(1)) : SUM_W'(dx_reg);
    assign y_step = (sum_neg_reg ^ sin_neg) ? (~SUM_W'(dy_reg) + SUM_W'(1)) : SUM_W'(dy_reg);
    assign x_sum  = {{(SUM_W-POS_W){pos_x_reg[POS_W-1]}}, pos_x_reg} + x_step;
    assign y_sum  = {{(SUM_W-POS_W){pos_y_reg[POS_W-1]}}, pos_y_reg} + y_step;

    assign pos_x_next   = sat_pos(x_sum);
    assign pos_y_next   = sat_pos(y_sum);
    assign heading_next = diff_neg_reg ? (heading_reg - dth_reg) : (heading_reg + dth_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_x_reg   <= '0;
            pos_y_reg   <= '0;
            heading_reg <= '0;
        end else if (cmd.update) begin
            pos_x_reg   <= pos_x_next;
            pos_y_reg   <= pos_y_next;
            heading_reg <= heading_next;
        end
    end

    assign status.mul_done    = mul_done;
    assign status.cordic_busy = cordic_busy;

    assign out_data.pose_x       = pos_x_reg;
    assign out_data.pose_y       = pos_y_reg;
    assign out_data.pose_heading = heading_reg;

endmodule

`default_nettype wire

[design/ddo_ctrl.sv]
// Odometry controller: sequences the eight shared-multiplier operations, the
// CORDIC launch, the pose update and the result handshake. Uses ddo_pkg.
`default_nettype none

module ddo_ctrl import ddo_pkg::*; (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  wire logic         m_ready,
    input  wire ddo_status_t  status,
    output ddo_cmd_t          cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_WAIT   = 2'd1;
    localparam logic [1:0] ST_ISSUE  = 2'd2;
    localparam logic [1:0] ST_UPDATE = 2'd3;

    logic [1:0]      state_reg, state_next;
    logic [OP_W-1:0] op_reg, op_next, op_inc;
    logic            m_valid_reg, m_valid_next;

    assign op_inc = op_reg + OP_W'(1);

    always_comb begin
        state_next   = state_reg;
        op_next      = op_reg;
        m_valid_next = m_valid_reg;
        cmd          = '0;
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load      = 1'b1;
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = OP_PHASE;
                    op_next       = OP_PHASE;
                    state_next    = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (status.mul_done) begin
                    cmd.wb    = 1'b1;
                    cmd.wb_op = op_reg;
                    if (op_reg == OP_DY) begin
                        state_next = ST_UPDATE;
                    end else if (op_inc == OP_ANGLE ||
                                 (op_inc == OP_DX && status.cordic_busy)) begin
                        op_next    = op_inc;
                        state_next = ST_ISSUE;
                    end else begin
                        cmd.mul_start = 1'b1;
                        cmd.mul_op    = op_inc;
                        op_next       = op_inc;
                    end
                end
            end
            ST_ISSUE: begin
                // hold the cosine product until the rotation has settled
                if (!(op_reg == OP_DX && status.cordic_busy)) begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_op    = op_reg;
                    state_next    = ST_WAIT;
                end
            end
            ST_UPDATE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.update   = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            op_reg      <= OP_PHASE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            op_reg      <= op_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

`default_nettype wire

[design/diff_drive_odometry.sv]
// Differential-drive odometry integrator, top level. Uses ddo_pkg,
// ddo_ctrl and ddo_datapath.
//
// Each request carries two wheel velocities and an elapsed time; the block
// advances the stored pose (x, y, heading) and returns the new pose. One
// request is in work at a time; the next is accepted only after its pose
// update, which waits until the previous pose has been taken. The time per
// request is set by the single 48x16 multiplier, which runs eight products
// in turn, and by the one-iteration-per-cycle CORDIC that must finish before
// the cosine product starts. A finished pose waits in the output register
// while the next request is accepted and computed; the pose update stalls
// until that pose is taken. The user must write the registers through the
// cfg port only while the block is idle; the block itself does not enforce
// this. Both registers reset to zero.
`default_nettype none

module diff_drive_odometry import ddo_pkg::*; #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [CFG_INDEX_W-1:0] cfg_wr_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wr_data,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire ddo_in_t                s_data,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output ddo_out_t                    m_data
);

    ddo_cmd_t    cmd;
    ddo_status_t status;

    ddo_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ddo_datapath #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_datapath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .in_data      (s_data),
        .cmd          (cmd),
        .status       (status),
        .out_data     (m_data)
    );

endmodule

`default_nettype wire

[design/ddo_checker.sv]
// Port-level checks of the odometry block, bound to diff_drive_odometry.
// Uses ddo_pkg for the result type.
`default_nettype none

module ddo_checker import ddo_pkg::*; (
    input wire logic     aclk,
    input wire logic     aresetn,
    input wire logic     s_valid,
    input wire logic     s_ready,
    input wire logic     m_valid,
    input wire logic     m_ready,
    input wire ddo_out_t m_data
);

    logic [1:0] pending_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(s_valid && s_ready) - 2'(m_valid && m_ready);
        end
    end

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_result_has_request: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> pending_reg != 2'd0)
        else $error("result without an accepted request");

    a_pending_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg != 2'd3)
        else $error("more than two requests outstanding");

    a_one_request_in_work: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("request accepted on back-to-back cycles");

    a_stalled_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result dropped or changed");

endmodule

bind diff_drive_odometry ddo_checker u_ddo_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

[bench/tb_diff_drive_odometry.sv]
// Testbench for diff_drive_odometry: a directed table, then random requests
// under several register settings, each pose checked against a pose integrator.
// Depends on ddo_pkg and the diff_drive_odometry RTL only.
`timescale 1ns / 100ps

module tb_diff_drive_odometry;
    import ddo_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int NUM_ROWS     = 26;
    localparam int PHASES       = 5;
    localparam int PHASE_REQS   = 250;

    localparam logic [CFG_INDEX_W-1:0] REG_NONE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_NONE_HI = 2'd3;

    localparam logic [31:0] VEL_MAX  = 32'h7FFF_FFFF;
    localparam logic [31:0] VEL_MIN  = 32'h8000_0000;
    localparam logic [31:0] VEL_ONE  = 32'h0001_0000;
    localparam logic [31:0] DT_ONE   = 32'h0100_0000;
    localparam logic [31:0] DT_HALF  = 32'h0080_0000;
    localparam logic [31:0] WORD_MAX = 32'hFFFF_FFFF;

    localparam logic [63:0] PHASE_PER_RAD    = 64'd44798133900177;
    localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
    localparam logic signed [63:0] GAIN_Q30  = 64'sd652032874;
    localparam logic signed [63:0] POS_MAX   = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [63:0] POS_MIN   = 64'shFFFF_8000_0000_0000;
    localparam logic [63:0] STEP_CLAMP       = 64'h4000_0000_0000_0000;

    typedef enum logic {ROW_REQ, ROW_WRITE} row_kind_e;

    typedef struct packed {
        row_kind_e             kind;
        ddo_in_t               req;
        logic [CFG_INDEX_W-1:0] index;
        logic [31:0]           value;
        logic                  at_rest;
    } row_t;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_wr_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wr_data = '0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    ddo_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    ddo_out_t m_data;

    logic signed [63:0] track_x = '0;
    logic signed [63:0] track_y = '0;
    logic [31:0]        track_heading = '0;
    logic [31:0]        radius_cfg = '0;
    logic [31:0]        ratio_cfg = '0;

    ddo_out_t pending_poses [$];
    int       errors = 0;
    int       idle_cycles = 0;
    bit       gaps_on = 1'b1;

    diff_drive_odometry #(.CORDIC_STEPS(CORDIC_STEPS)) dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always #5 aclk = ~aclk;

    function automatic logic [63:0] round_shift(input logic [63:0] a, input logic [63:0] b,
                                                input int unsigned s);
        logic [127:0] p;
        logic [127:0] q;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (s - 1));
        if ((p >> (64 + s)) != 128'd0) return 64'hFFFF_FFFF_FFFF_FFFF;
        q = p >> s;
        return q[63:0];
    endfunction

    function automatic logic signed [63:0] arctan_q30(input int i);
        case (i)
            0:  return 64'sd843314857;
            1:  return 64'sd497837829;
            2:  return 64'sd263043837;
            3:  return 64'sd133525159;
            4:  return 64'sd67021687;
            5:  return 64'sd33543516;
            6:  return 64'sd16775851;
            7:  return 64'sd8388437;
            8:  return 64'sd4194283;
            9:  return 64'sd2097149;
            10: return 64'sd1048576;
            11: return 64'sd524288;
            12: return 64'sd262144;
            13: return 64'sd131072;
            14: return 64'sd65536;
            15: return 64'sd32768;
            default: return 64'sd0;
        endcase
    endfunction

    function automatic void heading_sin_cos(input logic [31:0] h,
                                            output logic signed [63:0] cos_q,
                                            output logic signed [63:0] sin_q);
        logic [63:0]        turn;
        logic [31:0]        phase;
        logic [63:0]        zq;
        logic signed [63:0] x, y, z, xs, ys;
        turn  = {{32{h[31]}}, h} * PHASE_PER_RAD;
        phase = turn[63:32];
        zq    = ({34'd0, phase[29:0]} * QUARTER_TURN_Q30) >> 30;
        z     = zq;
        x     = GAIN_Q30;
        y     = '0;
        for (int i = 0; i < CORDIC_STEPS; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x = x - ys;
                y = y + xs;
                z = z - arctan_q30(i);
            end else begin
                x = x + ys;
                y = y - xs;
                z = z + arctan_q30(i);
            end
        end
        case (phase[31:30])
            2'd0: begin cos_q = x;  sin_q = y;  end
            2'd1: begin cos_q = -y; sin_q = x;  end
            2'd2: begin cos_q = -x; sin_q = -y; end
            default: begin cos_q = y; sin_q = -x; end
        endcase
    endfunction

    function automatic logic signed [63:0] scaled_step(input logic [63:0] travel,
                                                       input bit neg,
                                                       input logic signed [63:0] f);
        logic [63:0] mag, r;
        bit          n;
        mag = (f < 0) ? -f : f;
        r   = round_shift(travel, mag, 30);
        n   = neg ^ (f < 0);
        if (r > STEP_CLAMP) r = STEP_CLAMP;
        return n ? -$signed(r) : $signed(r);
    endfunction

    function automatic logic signed [63:0] clamp48(input logic signed [63:0] v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // advance the tracked pose by one request and return the new pose
    function automatic ddo_out_t advance_pose(input ddo_in_t req);
        logic signed [63:0] va, vb, sum, diff, c, s;
        logic [63:0]        sum_mag, diff_mag, speed, rate, travel, dth;
        ddo_out_t           pose;
        va       = {{32{req.velocity_a[31]}}, req.velocity_a};
        vb       = {{32{req.velocity_b[31]}}, req.velocity_b};
        sum      = va + vb;
        diff     = va - vb;
        sum_mag  = (sum < 0) ? -sum : sum;
        diff_mag = (diff < 0) ? -diff : diff;
        speed    = round_shift(sum_mag, {32'd0, radius_cfg}, 25);
        rate     = round_shift(diff_mag, {32'd0, ratio_cfg}, 24);
        travel   = round_shift(speed, {32'd0, req.elapsed_time}, 24);
        dth      = round_shift(rate, {32'd0, req.elapsed_time}, 24);
        heading_sin_cos(track_heading, c, s);
        track_x = clamp48(track_x + scaled_step(travel, sum < 0, c));
        track_y = clamp48(track_y + scaled_step(travel, sum < 0, s));
        if (diff < 0) track_heading = track_heading - dth[31:0];
        else track_heading = track_heading + dth[31:0];
        pose.pose_x       = track_x[47:0];
        pose.pose_y       = track_y[47:0];
        pose.pose_heading = track_heading;
        return pose;
    endfunction

    function automatic row_t req_row(input logic [31:0] a, input logic [31:0] b,
                                     input logic [31:0] dt, input bit at_rest);
        row_t r;
        r = '0;
        r.kind             = ROW_REQ;
        r.req.velocity_a   = a;
        r.req.velocity_b   = b;
        r.req.elapsed_time = dt;
        r.at_rest          = at_rest;
        return r;
    endfunction

    function automatic row_t write_row(input logic [CFG_INDEX_W-1:0] index,
                                       input logic [31:0] value);
        row_t r;
        r = '0;
        r.kind  = ROW_WRITE;
        r.index = index;
        r.value = value;
        return r;
    endfunction

    function automatic logic [31:0] extreme_word();
        case ($urandom_range(0, 4))
            0: return VEL_MAX;
            1: return VEL_MIN;
            2: return 32'd0;
            3: return WORD_MAX;
            default: return 32'd1;
        endcase
    endfunction

    // wheel speed within about +-60 rad/s
    function automatic logic [31:0] wheel_speed();
        return $urandom_range(0, 7864320) - 32'd3932160;
    endfunction

    function automatic ddo_in_t random_request();
        ddo_in_t r;
        case ($urandom_range(0, 9))
            0: begin
                r.velocity_a   = $urandom;
                r.velocity_b   = $urandom;
                r.elapsed_time = $urandom;
            end
            1: begin
                r.velocity_a   = extreme_word();
                r.velocity_b   = extreme_word();
                r.elapsed_time = extreme_word();
            end
            default: begin
                r.velocity_a   = wheel_speed();
                r.velocity_b   = ($urandom_range(0, 3) == 0) ? r.velocity_a : wheel_speed();
                r.elapsed_time = $urandom_range(0, 335544);
            end
        endcase
        return r;
    endfunction

    function automatic bit same_field(input string name, input logic [47:0] want,
                                      input logic [47:0] got);
        if (want === got) return 1'b1;
        $display("%0t: pose %s mismatch, expected %h actual %h", $time, name, want, got);
        return 1'b0;
    endfunction

    task automatic check_pose(input ddo_out_t got);
        ddo_out_t want;
        bit       ok;
        if (pending_poses.size() == 0) begin
            errors++;
            $display("%0t: pose with no request pending, actual %h", $time, got);
        end else begin
            want = pending_poses.pop_front();
            ok = same_field("x", want.pose_x, got.pose_x)
               & same_field("y", want.pose_y, got.pose_y)
               & same_field("heading", {16'd0, want.pose_heading}, {16'd0, got.pose_heading});
            if (!ok) errors++;
        end
    endtask

    task automatic send_request(input ddo_in_t req, input bit at_rest);
        int unsigned gap;
        ddo_out_t    pose;
        gap = gaps_on ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        pose = advance_pose(req);
        if (at_rest) pose = '0;
        pending_poses.push_back(pose);
    endtask

    task automatic drain_poses();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_poses.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] index, input logic [31:0] value);
        @(posedge aclk);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= index;
        cfg_wr_data  <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (index == REG_WHEEL_RADIUS) radius_cfg = value;
        else if (index == REG_RADIUS_OVER_TRACK) ratio_cfg = value;
    endtask

    initial begin
        int unsigned stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            stall = gaps_on ? $urandom_range(0, 19) : 0;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            check_pose(m_data);
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        row_t rows [NUM_ROWS];
        rows[0]  = req_row(VEL_MAX, VEL_MAX, WORD_MAX, 1'b1);
        rows[1]  = req_row(VEL_MIN, VEL_MIN, WORD_MAX, 1'b1);
        rows[2]  = req_row(VEL_MIN, VEL_MAX, WORD_MAX, 1'b1);
        rows[3]  = req_row(VEL_MAX, VEL_MIN, DT_ONE, 1'b1);
        rows[4]  = write_row(REG_WHEEL_RADIUS, DT_ONE);
        rows[5]  = write_row(REG_RADIUS_OVER_TRACK, DT_HALF);
        rows[6]  = req_row(VEL_ONE, VEL_ONE, DT_ONE, 1'b0);
        rows[7]  = req_row(VEL_ONE, -VEL_ONE, DT_ONE, 1'b0);
        rows[8]  = req_row(-VEL_ONE, VEL_ONE, DT_ONE, 1'b0);
        rows[9]  = req_row(-(VEL_ONE << 1), -VEL_ONE, DT_HALF, 1'b0);
        rows[10] = req_row(32'd0, 32'd0, WORD_MAX, 1'b0);
        rows[11] = req_row(VEL_MAX, VEL_MAX, 32'd0, 1'b0);
        rows[12] = write_row(REG_NONE_LO, WORD_MAX);
        rows[13] = write_row(REG_NONE_HI, WORD_MAX);
        rows[14] = req_row(VEL_ONE, 32'd0, DT_ONE, 1'b0);
        rows[15] = write_row(REG_WHEEL_RADIUS, WORD_MAX);
        rows[16] = write_row(REG_RADIUS_OVER_TRACK, WORD_MAX);
        rows[17] = req_row(VEL_MAX, VEL_MAX, WORD_MAX, 1'b0);
        rows[18] = req_row(VEL_MAX, VEL_MAX, WORD_MAX, 1'b0);
        rows[19] = req_row(VEL_MAX, VEL_MIN, WORD_MAX, 1'b0);
        rows[20] = req_row(VEL_MIN, VEL_MIN, WORD_MAX, 1'b0);
        rows[21] = req_row(VEL_MIN, VEL_MIN, WORD_MAX, 1'b0);
        rows[22] = req_row(VEL_MIN, VEL_MAX, WORD_MAX, 1'b0);
        rows[23] = req_row(WORD_MAX, 32'd1, 32'd1, 1'b0);
        rows[24] = req_row(32'd1, 32'd1, 32'd1, 1'b0);
        rows[25] = req_row(VEL_MAX, VEL_MAX, WORD_MAX, 1'b0);

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        for (int i = 0; i < NUM_ROWS; i++) begin
            if (rows[i].kind == ROW_WRITE) begin
                drain_poses();
                write_reg(rows[i].index, rows[i].value);
            end else begin
                send_request(rows[i].req, rows[i].at_rest);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            drain_poses();
            gaps_on = (phase != 1);
            case (phase)
                0, 4: begin
                    write_reg(REG_WHEEL_RADIUS, $urandom_range(335544, 8388608));
                    write_reg(REG_RADIUS_OVER_TRACK, $urandom_range(838861, 33554432));
                    write_reg(REG_NONE_HI, $urandom);
                end
                1: begin
                    write_reg(REG_WHEEL_RADIUS, $urandom);
                    write_reg(REG_RADIUS_OVER_TRACK, $urandom);
                end
                2: begin
                    write_reg(REG_WHEEL_RADIUS, WORD_MAX);
                    write_reg(REG_RADIUS_OVER_TRACK, 32'd0);
                end
                default: begin
                    write_reg(REG_WHEEL_RADIUS, 32'd0);
                    write_reg(REG_RADIUS_OVER_TRACK, WORD_MAX);
                end
            endcase
            for (int n = 0; n < PHASE_REQS; n++) begin
                // hold off until the pipeline has emptied now and then
                if (n % 125 == 124) drain_poses();
                send_request(random_request(), 1'b0);
            end
        end

        drain_poses();
        repeat (40) @(posedge aclk);
        if (errors == 0 && pending_poses.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
